/* rtl/core/prd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// prd_pkg
// Shared widths, defaults and the stage record of the pattern RLE decoder.
// ----------------------------------------------------------------------------
package prd_pkg;

   localparam int BYTE_W        = 8;
   localparam int PATTERN_DEPTH = 512;
   localparam int POS_W         = 9;
   localparam int REP_W         = 15;
   localparam int RUN_W         = 8;
   localparam int HDR_W         = 4;
   localparam int HDR_BYTES     = 8;

   localparam logic [BYTE_W-1:0] MODE_MASK  = 8'h80;
   localparam logic [BYTE_W-1:0] COUNT_MASK = 8'h7F;

   // one result on its way from the state update to the output register
   typedef struct packed {
      logic              out_valid;
      logic [BYTE_W-1:0] out_byte;
      logic              use_mem;
      logic              token_done;
      logic              more_pending;
      logic              misuse;
   } prd_result_type;

endpackage
`default_nettype wire

/* rtl/core/prd_pattern_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// prd_pattern_ram
// Pattern byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module prd_pattern_ram #(
   parameter int DEPTH = prd_pkg::PATTERN_DEPTH,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [AW-1:0]               wr_addr,
   input  wire logic [prd_pkg::BYTE_W-1:0]  wr_data,
   input  wire logic                        rd_en,
   input  wire logic [AW-1:0]               rd_addr,
   output logic      [prd_pkg::BYTE_W-1:0]  rd_data
);

   logic [prd_pkg::BYTE_W-1:0] mem_ff [DEPTH];
   logic [prd_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/core/pattern_rle_decompressor.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pattern_rle_decompressor
// Run-length decoder with literal and stored-pattern tokens; repeats after
// the first copy are drawn out by pull requests.
// ----------------------------------------------------------------------------
// Results: each result is held in stage one, then in the output register.
// Throughput: one request per cycle unless stalled; each request does at most
//   one RAM access (a write for a pattern byte, a read for a pattern pull).
// Reset: synchronous, active high; clears the parser, counters and pipeline,
//   sets skip_header to 1. The pattern store is not cleared: every entry is
//   written by a pattern token before any pull reads it.
// ----------------------------------------------------------------------------
module pattern_rle_decompressor #(
   parameter int PATTERN_DEPTH = prd_pkg::PATTERN_DEPTH
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // request channel
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_type,
   input  wire logic [prd_pkg::BYTE_W-1:0]  req_in_byte,
   input  wire logic                        req_stream_end,
   // result channel
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_out_valid,
   output logic      [prd_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                             rsp_token_done,
   output logic                             rsp_more_pending,
   output logic                             rsp_misuse,
   // configuration
   input  wire logic                        csr_wr_en,
   input  wire logic                        csr_wr_data
);

   localparam int AW = $clog2(PATTERN_DEPTH);

   // parser phases
   localparam logic [2:0] PH_HEADER     = 3'd0;
   localparam logic [2:0] PH_TOKEN      = 3'd1;
   localparam logic [2:0] PH_LITVAL     = 3'd2;
   localparam logic [2:0] PH_PATLEN     = 3'd3;
   localparam logic [2:0] PH_PATDATA    = 3'd4;
   localparam logic [2:0] PH_REPEAT     = 3'd5;
   localparam logic [2:0] PH_REPEAT_END = 3'd6;

   // ------------------------------------------------------------------------
   // Decoder state. Scalars live in flops; pattern bytes live in the RAM.
   // ------------------------------------------------------------------------
   logic                          skip_hdr_ff;
   logic [2:0]                    phase_ff,   phase_in;
   logic [prd_pkg::HDR_W-1:0]     hdr_cnt_ff, hdr_cnt_in;
   logic [prd_pkg::RUN_W-1:0]     run_ff,     run_in;
   logic [prd_pkg::POS_W-1:0]     len_ff,     len_in;
   logic [prd_pkg::POS_W-1:0]     pos_ff,     pos_in;
   logic [prd_pkg::REP_W-1:0]     rep_ff,     rep_in;
   logic [prd_pkg::BYTE_W-1:0]    lit_ff,     lit_in;

   // pipeline: stage one waits on the RAM read, then the output register
   logic                          s1_valid_ff, s1_valid_in;
   prd_pkg::prd_result_type       s1_ff,       s1_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   prd_pkg::prd_result_type       rsp_ff,       rsp_in;
   logic                          s1_adv;
   logic                          req_xfer;

   // RAM access for the current request
   logic                          ram_wr_en;
   logic                          ram_rd_en;
   logic [prd_pkg::BYTE_W-1:0]    ram_rd_data;

   // request decode helpers
   logic                          repeating;
   logic                          complete;
   logic [prd_pkg::HDR_W-1:0]     hdr_next;
   logic [prd_pkg::POS_W:0]       pos_inc;
   logic [prd_pkg::RUN_W-1:0]     run_less;
   logic [prd_pkg::RUN_W+prd_pkg::POS_W-1:0] rep_product;

   // Stage one moves on whenever the output register is free or drained this
   // cycle. A request transfers only if stage one has room, so the RAM read
   // data stays put while stage one holds.
   assign s1_adv    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_xfer  = req_valid && !req_stall;

   assign repeating   = (phase_ff == PH_REPEAT) || (phase_ff == PH_REPEAT_END);
   assign hdr_next    = hdr_cnt_ff + 1'b1;
   assign pos_inc     = {1'b0, pos_ff} + 1'b1;
   assign run_less    = run_ff - 1'b1;
   // small multiply: count less one times pattern length
   assign rep_product = run_less * len_ff;

   // ------------------------------------------------------------------------
   // Per-request state update and result
   // ------------------------------------------------------------------------
   always_comb begin
      phase_in   = phase_ff;
      hdr_cnt_in = hdr_cnt_ff;
      run_in     = run_ff;
      len_in     = len_ff;
      pos_in     = pos_ff;
      rep_in     = rep_ff;
      lit_in     = lit_ff;
      ram_wr_en  = 1'b0;
      ram_rd_en  = 1'b0;
      complete   = 1'b0;
      s1_in      = '0;

      if (req_type) begin
         // pull: emit one repeat byte
         if (!repeating || (rep_ff == '0)) begin
            s1_in.misuse = 1'b1;
         end else begin
            s1_in.out_valid = 1'b1;
            if (len_ff == '0) begin
               s1_in.out_byte = lit_ff;
            end else begin
               s1_in.use_mem = 1'b1;
               ram_rd_en     = 1'b1;
               pos_in = (pos_inc >= {1'b0, len_ff}) ? '0 : pos_inc[prd_pkg::POS_W-1:0];
            end
            rep_in = rep_ff - 1'b1;
            if (rep_in == '0) begin
               s1_in.token_done = 1'b1;
               if (phase_ff == PH_REPEAT_END) begin
                  phase_in   = PH_HEADER;
                  hdr_cnt_in = '0;
               end else begin
                  phase_in = PH_TOKEN;
               end
            end
         end
      end else if (repeating) begin
         // data while repeats are pending: drop it
         s1_in.misuse = 1'b1;
      end else begin
         if ((phase_ff == PH_HEADER) && skip_hdr_ff) begin
            // skip the stream length bytes
            if (hdr_next >= prd_pkg::HDR_W'(prd_pkg::HDR_BYTES)) begin
               hdr_cnt_in = '0;
               phase_in   = PH_TOKEN;
               if (req_stream_end) begin
                  phase_in = PH_HEADER;
                  complete = 1'b1;
               end
            end else begin
               hdr_cnt_in = hdr_next;
            end
         end else if ((phase_ff == PH_HEADER) || (phase_ff == PH_TOKEN)) begin
            run_in   = (req_in_byte & prd_pkg::COUNT_MASK) + 1'b1;
            phase_in = ((req_in_byte & prd_pkg::MODE_MASK) != '0) ? PH_PATLEN : PH_LITVAL;
         end else if (phase_ff == PH_LITVAL) begin
            lit_in          = req_in_byte;
            len_in          = '0;
            s1_in.out_valid = 1'b1;
            s1_in.out_byte  = req_in_byte;
            complete        = 1'b1;
            if (run_ff > 1) begin
               rep_in   = prd_pkg::REP_W'(run_less);
               phase_in = req_stream_end ? PH_REPEAT_END : PH_REPEAT;
            end else begin
               s1_in.token_done = 1'b1;
               phase_in         = req_stream_end ? PH_HEADER : PH_TOKEN;
            end
         end else if (phase_ff == PH_PATLEN) begin
            len_in   = {1'b0, req_in_byte} + 2'd2;
            pos_in   = '0;
            phase_in = PH_PATDATA;
         end else begin
            // pattern byte: store and pass through
            ram_wr_en       = 1'b1;
            s1_in.out_valid = 1'b1;
            s1_in.out_byte  = req_in_byte;
            if (pos_inc[prd_pkg::POS_W-1:0] >= len_ff) begin
               pos_in   = '0;
               complete = 1'b1;
               if (run_ff > 1) begin
                  rep_in   = rep_product[prd_pkg::REP_W-1:0];
                  phase_in = req_stream_end ? PH_REPEAT_END : PH_REPEAT;
               end else begin
                  s1_in.token_done = 1'b1;
                  phase_in         = req_stream_end ? PH_HEADER : PH_TOKEN;
               end
            end else begin
               pos_in = pos_inc[prd_pkg::POS_W-1:0];
            end
         end

         // end of stream in the middle of a token: flag and restart
         if (req_stream_end && !complete) begin
            s1_in.misuse     = 1'b1;
            s1_in.token_done = 1'b0;
            phase_in         = PH_HEADER;
            hdr_cnt_in       = '0;
            rep_in           = '0;
         end
         if (req_stream_end && complete && (phase_in == PH_HEADER)) begin
            hdr_cnt_in = '0;
         end
      end

      s1_in.more_pending = ((phase_in == PH_REPEAT) || (phase_in == PH_REPEAT_END)) &&
                           (rep_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_hdr_ff <= 1'b1;
         phase_ff    <= PH_HEADER;
         hdr_cnt_ff  <= '0;
         run_ff      <= '0;
         len_ff      <= '0;
         pos_ff      <= '0;
         rep_ff      <= '0;
         lit_ff      <= '0;
      end else begin
         if (csr_wr_en) begin
            skip_hdr_ff <= csr_wr_data;
         end
         if (req_xfer) begin
            phase_ff   <= phase_in;
            hdr_cnt_ff <= hdr_cnt_in;
            run_ff     <= run_in;
            len_ff     <= len_in;
            pos_ff     <= pos_in;
            rep_ff     <= rep_in;
            lit_ff     <= lit_in;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Pattern store. Writes and reads are addressed by the current position;
   // a pull always comes after the last write of its pattern, so no forwarding
   // is needed.
   // ------------------------------------------------------------------------
   prd_pattern_ram #(
      .DEPTH (PATTERN_DEPTH),
      .AW    (AW)
   ) u_pattern_ram (
      .clock   (clock),
      .wr_en   (req_xfer && ram_wr_en),
      .wr_addr (AW'(pos_ff)),
      .wr_data (req_in_byte),
      .rd_en   (req_xfer && ram_rd_en),
      .rd_addr (AW'(pos_ff)),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------------
   // Result pipeline: stage one, then the output register
   // ------------------------------------------------------------------------
   always_comb begin
      s1_valid_in = req_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s1_adv ? s1_valid_ff : rsp_valid_ff;
      rsp_in       = s1_ff;
      // merge the RAM read data for pattern pulls
      if (s1_ff.use_mem) begin
         rsp_in.out_byte = ram_rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: load on transfer or advance, hold otherwise
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_ff <= s1_in;
      end
      if (s1_adv && s1_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_valid    = rsp_ff.out_valid;
   assign rsp_out_byte     = rsp_ff.out_byte;
   assign rsp_token_done   = rsp_ff.token_done;
   assign rsp_more_pending = rsp_ff.more_pending;
   assign rsp_misuse       = rsp_ff.misuse;

endmodule
`default_nettype wire
